// ===== rtl/smt_pkg.sv =====
// Package for the stroke motion tracker: widths, constants and the CORDIC angle table.
`default_nettype none
package smt_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int IN_W = 112;
  localparam int OUT_W = 152;
  localparam int CFG_W = 24;
  localparam int DIV_W = 80;
  localparam int DEN_W = 48;
  localparam logic [30:0] EXP_M1_Q32 = 31'd1580030169;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 24'd30000;
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [0:0] REG_MAX_SPEED = 1'b1;

  function automatic logic [31:0] cordic_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'd536870912;
      5'd1: t = 32'd316933406;
      5'd2: t = 32'd167458907;
      5'd3: t = 32'd85004756;
      5'd4: t = 32'd42667331;
      5'd5: t = 32'd21354465;
      5'd6: t = 32'd10679838;
      5'd7: t = 32'd5340245;
      5'd8: t = 32'd2670163;
      5'd9: t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      5'd30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/stroke_motion_tracker.sv =====
// Stroke motion tracker: per-sample path, time, pressure, heading, smoothed and normalised speed.
// One request is taken while the block is idle. A request that opens a stroke skips the
// path, heading and speed work and runs only the normalising division, when max_speed
// is nonzero. A continuing request takes longer with a move, a time step and a nonzero
// max_speed, and longer again per exponential series term. The series always ends
// within 13 terms. The work is done by one shared one-bit-per-cycle divider (33 to 61
// steps per division, one division per series term), one shared 34x34 multiplier, a
// 26-step square root, a 32-step CORDIC and up to 31 decay multiplications. The finished
// result sits in an output register, so the next request can be taken while it waits.
`default_nettype none
module stroke_motion_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // pos_x[23:0], pos_y[47:24], pressure[63:48], time_us[111:64]
  input  wire logic [smt_pkg::IN_W-1:0]    s_tdata,
  // start_stroke
  input  wire logic                        s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // distance_total[39:0], elapsed_us[79:40], peak_pressure[95:80], heading[111:96],
  // speed_smoothed[135:112], speed_norm[151:136]
  output logic [smt_pkg::OUT_W-1:0]        m_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [smt_pkg::CFG_W-1:0]   cfg_data
);
  localparam logic [4:0] ST_IDLE = 5'd0, ST_SQX = 5'd1, ST_SQY = 5'd2, ST_SQS = 5'd3,
    ST_ROOT = 5'd4, ST_RND = 5'd5, ST_CORD = 5'd6, ST_CFIN = 5'd7, ST_LEN = 5'd8,
    ST_INST = 5'd9, ST_DIV = 5'd10, ST_RATE = 5'd11, ST_FRAC = 5'd12, ST_TMUL = 5'd13,
    ST_TDIV = 5'd14, ST_TERM = 5'd15, ST_EXP = 5'd16, ST_EMUL = 5'd17, ST_EMUL2 = 5'd18,
    ST_EMA = 5'd19, ST_EMA2 = 5'd20, ST_NORM = 5'd21, ST_NSAT = 5'd22, ST_DONE = 5'd23;

  localparam int AB = smt_pkg::ANGLE_BITS;
  localparam int DIV_W = smt_pkg::DIV_W;
  localparam int DEN_W = smt_pkg::DEN_W;
  localparam int SH_R = (AB >= 16) ? AB - 16 : 0;
  localparam int SH_L = (AB >= 16) ? 0 : 16 - AB;
  localparam logic [39:0] M40 = {40{1'b1}};
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  logic [4:0]  state, div_ret;
  logic [23:0] win, max_spd;
  logic        active;
  logic [23:0] prev_x, prev_y;
  logic [47:0] clock_mark, gap;
  logic [39:0] path_length, time_sum;
  logic [15:0] pressure_peak, direction, norm;
  logic [23:0] speed_avg, rate;
  logic signed [24:0] dx, dy;
  logic [49:0] sq;
  logic [51:0] rv, rr, rbit;
  logic [25:0] len;
  logic [6:0]  cnt;
  logic signed [47:0] cx, cy;
  logic [31:0] ang;
  logic [4:0]  ci;
  logic [DIV_W-1:0] num;
  logic [DEN_W-1:0] den, rem;
  logic [4:0]  n_int;
  logic [31:0] frac;
  logic [32:0] term, e_val, gain;
  logic signed [34:0] sum;
  logic [5:0]  k;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic        out_valid;
  logic [smt_pkg::OUT_W-1:0] out_data;

  logic signed [24:0] px, py;
  logic [15:0] pr;
  logic [47:0] now, gap_in;
  logic [40:0] tsum_add, path_add;
  logic [DEN_W:0] rem_sh;
  logic        div_ge;
  logic [51:0] root_t;
  logic signed [47:0] xs, ys;
  logic [32:0] ang_rnd;
  logic [AB-1:0] q_ang;
  logic signed [24:0] diff;
  logic signed [67:0] ema_sum;
  logic signed [35:0] ema_step;
  logic signed [36:0] nv;
  logic [25:0] len_rnd;
  logic [28:0] win32;

  assign px = {s_tdata[23], s_tdata[23:0]};
  assign py = {s_tdata[47], s_tdata[47:24]};
  assign pr = s_tdata[63:48];
  assign now = s_tdata[111:64];
  assign gap_in = (now > clock_mark) ? now - clock_mark : '0;
  assign tsum_add = {1'b0, time_sum} + {1'b0, gap_in[39:0]};
  assign rem_sh = {rem, num[DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, den};
  assign root_t = rr + rbit;
  assign xs = cx >>> ci;
  assign ys = cy >>> ci;
  assign ang_rnd = {1'b0, ang} + 33'(33'd1 << (31 - AB));
  assign q_ang = ang_rnd[31:32-AB];
  assign len_rnd = 26'(rr) + ((rv > rr) ? 26'd1 : 26'd0);
  assign path_add = {1'b0, path_length} + 41'(len_rnd);
  assign diff = $signed({1'b0, rate}) - $signed({1'b0, speed_avg});
  assign ema_sum = prod + 68'sd2147483648;
  assign ema_step = 36'(ema_sum >>> 32);
  assign nv = $signed({13'd0, speed_avg}) + 37'(ema_step);
  assign win32 = {win, 5'd0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQX: begin
        mul_a = 34'(dx);
        mul_b = 34'(dx);
      end
      ST_SQY: begin
        mul_a = 34'(dy);
        mul_b = 34'(dy);
      end
      ST_LEN: begin
        mul_a = $signed({8'd0, len});
        mul_b = 34'sd1000;
      end
      ST_TMUL: begin
        mul_a = $signed({1'b0, term});
        mul_b = $signed({2'd0, frac});
      end
      ST_EMUL: begin
        mul_a = $signed({1'b0, e_val});
        mul_b = $signed({3'd0, smt_pkg::EXP_M1_Q32});
      end
      ST_EMA: begin
        mul_a = 34'(diff);
        mul_b = $signed({1'b0, gain});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= 1'b0;
      out_valid <= 1'b0;
      win <= smt_pkg::WINDOW_RESET;
      max_spd <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          smt_pkg::REG_WINDOW: win <= cfg_data;
          smt_pkg::REG_MAX_SPEED: max_spd <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && m_tready && state != ST_DONE) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            prev_x <= s_tdata[23:0];
            prev_y <= s_tdata[47:24];
            dx <= px - $signed({prev_x[23], prev_x});
            dy <= py - $signed({prev_y[23], prev_y});
            if (s_tuser || !active) begin
              active <= 1'b1;
              path_length <= '0;
              time_sum <= '0;
              direction <= '0;
              speed_avg <= '0;
              pressure_peak <= pr;
              clock_mark <= now;
              state <= ST_NORM;
            end else begin
              gap <= gap_in;
              time_sum <= (tsum_add[40] || gap_in[47:40] != 8'd0) ? M40 : tsum_add[39:0];
              if (pr > pressure_peak) pressure_peak <= pr;
              if (gap_in != '0) clock_mark <= now;
              state <= ST_SQX;
            end
          end
        end
        ST_SQX: state <= ST_SQY;
        ST_SQY: begin
          sq <= prod[49:0];
          state <= ST_SQS;
        end
        ST_SQS: begin
          sq <= sq + prod[49:0];
          rv <= 52'(sq + prod[49:0]);
          rr <= '0;
          rbit <= 52'd1 << 50;
          cnt <= 7'd26;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rv >= root_t) begin
            rv <= rv - root_t;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= ST_RND;
        end
        ST_RND: begin
          len <= len_rnd;
          path_length <= path_add[40] ? M40 : path_add[39:0];
          if (sq != '0) begin
            if (dx < 0) begin
              cx <= -($signed({{3{dx[24]}}, dx, 20'd0}));
              cy <= -($signed({{3{dy[24]}}, dy, 20'd0}));
              ang <= 32'h8000_0000;
            end else begin
              cx <= $signed({{3{dx[24]}}, dx, 20'd0});
              cy <= $signed({{3{dy[24]}}, dy, 20'd0});
              ang <= '0;
            end
            ci <= '0;
            state <= ST_CORD;
          end else if (gap != '0 && win != '0) begin
            state <= ST_LEN;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_CORD: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            ang <= ang + smt_pkg::cordic_turn(ci);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            ang <= ang - smt_pkg::cordic_turn(ci);
          end
          ci <= ci + 5'd1;
          if (ci == 5'd31) state <= ST_CFIN;
        end
        ST_CFIN: begin
          direction <= 16'((24'(q_ang) >> SH_R) << SH_L);
          state <= (gap != '0 && win != '0) ? ST_LEN : ST_NORM;
        end
        ST_LEN: state <= ST_INST;
        ST_INST: begin
          num <= DIV_W'(prod[47:0] + (gap >> 1)) << (DIV_W - 48);
          den <= gap;
          rem <= '0;
          cnt <= 7'd48;
          div_ret <= ST_RATE;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= div_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
          num <= {num[DIV_W-2:0], div_ge};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= div_ret;
        end
        ST_RATE: begin
          rate <= (num[47:24] != '0) ? 24'hFF_FFFF : num[23:0];
          if (gap >= 48'(win32)) begin
            gain <= ONE_Q32;
            state <= ST_EMA;
          end else begin
            num <= DIV_W'({gap, 32'd0}) << (DIV_W - 61);
            den <= 48'(win);
            rem <= '0;
            cnt <= 7'd61;
            div_ret <= ST_FRAC;
            state <= ST_DIV;
          end
        end
        ST_FRAC: begin
          n_int <= num[36:32];
          frac <= num[31:0];
          term <= ONE_Q32;
          sum <= 35'(ONE_Q32);
          k <= 6'd1;
          state <= ST_TMUL;
        end
        ST_TMUL: state <= ST_TDIV;
        ST_TDIV: begin
          num <= DIV_W'(prod[64:32]) << (DIV_W - 33);
          den <= 48'(k);
          rem <= '0;
          cnt <= 7'd33;
          div_ret <= ST_TERM;
          state <= ST_DIV;
        end
        ST_TERM: begin
          if (num[32:0] == '0) begin
            state <= ST_EXP;
          end else begin
            term <= num[32:0];
            sum <= k[0] ? sum - $signed({2'd0, num[32:0]}) : sum + $signed({2'd0, num[32:0]});
            k <= k + 6'd1;
            state <= (k == 6'd39) ? ST_EXP : ST_TMUL;
          end
        end
        ST_EXP: begin
          e_val <= (sum < 0) ? '0 : sum[32:0];
          state <= ST_EMUL;
        end
        ST_EMUL: begin
          if (n_int == '0) begin
            gain <= ONE_Q32 - e_val;
            state <= ST_EMA;
          end else begin
            state <= ST_EMUL2;
          end
        end
        ST_EMUL2: begin
          e_val <= prod[64:32];
          n_int <= n_int - 5'd1;
          state <= ST_EMUL;
        end
        ST_EMA: state <= ST_EMA2;
        ST_EMA2: begin
          if (nv < 0) speed_avg <= '0;
          else if (nv > 37'sd16777215) speed_avg <= 24'hFF_FFFF;
          else speed_avg <= nv[23:0];
          state <= ST_NORM;
        end
        ST_NORM: begin
          if (max_spd == '0) begin
            norm <= '0;
            state <= ST_DONE;
          end else begin
            num <= DIV_W'({speed_avg, 16'd0}) << (DIV_W - 40);
            den <= 48'(max_spd);
            rem <= '0;
            cnt <= 7'd40;
            div_ret <= ST_NSAT;
            state <= ST_DIV;
          end
        end
        ST_NSAT: begin
          norm <= (num[39:16] != '0) ? 16'hFFFF : num[15:0];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || m_tready) begin
            out_data <= {norm, speed_avg, direction, pressure_peak, time_sum, path_length};
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
